### hdl/tlvopf_pkg.sv
// Package for the TLV option pad filter: phase codes, state and result types.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package tlvopf_pkg;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
	localparam logic [7:0]  TYPE_PAD1      = 8'd0;
	localparam logic [7:0]  TYPE_PADN      = 8'd1;
	localparam logic [17:0] HDR_OVERHEAD   = 18'd2;

	typedef enum logic [5:0] {
		PH_TYPE    = 6'b000001,
		PH_PADLEN  = 6'b000010,
		PH_PADSKIP = 6'b000100,
		PH_OPTLEN  = 6'b001000,
		PH_OPTBODY = 6'b010000,
		PH_DRAIN   = 6'b100000
	} phase_t;

	typedef struct packed {
		phase_t      phase;
		logic [7:0]  bytes_left;
		logic [7:0]  held_type;
		logic [15:0] count_written;
	} state_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        byte_valid;
		logic        done_res;
		logic [15:0] written_count;
	} res_t;

	localparam state_t STATE_RESET = '{
		phase:         PH_TYPE,
		bytes_left:    8'd0,
		held_type:     8'd0,
		count_written: 16'd0
	};

endpackage

### hdl/tlv_option_pad_filter_top.sv
// Path: an accepted word is registered in the input stage; its results pass
// through the result buffer, which takes them once it has room for them.
// Throughput: one input word per cycle while the result buffer has room; an
// option header word yields two output words and so holds the input while the
// buffer has under two free entries. The two-entry buffer sets this figure.
// Reset: asynchronous, active low; clears the filter state, buffer count and
// sets capacity to 65535.
`timescale 1ns / 1ps

module tlv_option_pad_filter_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,   // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [7:0] out_byte, [23:8] written_count
	output logic        m_tuser,   // byte_valid
	output logic        m_tlast,   // done_res
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // capacity
);
	import tlvopf_pkg::*;

	logic        vld_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [15:0] capacity_q;
	state_t      st_q;
	state_t      st_next;
	logic [1:0]  res_n;
	res_t        res0;
	res_t        res1;
	logic [1:0]  space;
	logic        adv;
	logic        pop;
	res_t        head;

	assign cfg_ready = 1'b1;
	assign pop       = m_tvalid && m_tready;
	assign adv       = vld_s1 && (res_n <= space);
	assign s_tready  = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1     <= 1'b0;
			capacity_q <= CAPACITY_RESET;
			st_q       <= STATE_RESET;
		end else begin
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (cfg_valid && cfg_ready) begin
				capacity_q <= cfg_data;
			end
			if (adv) begin
				st_q <= st_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	tlvopf_step u_step (
		.st       (st_q),
		.in_byte  (byte_s1),
		.last     (last_s1),
		.capacity (capacity_q),
		.st_next  (st_next),
		.res_n    (res_n),
		.res0     (res0),
		.res1     (res1)
	);

	tlvopf_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_n     (adv ? res_n : 2'd0),
		.push0      (res0),
		.push1      (res1),
		.pop        (pop),
		.head_valid (m_tvalid),
		.head       (head),
		.space      (space)
	);

	assign m_tdata = {head.written_count, head.out_byte};
	assign m_tuser = head.byte_valid;
	assign m_tlast = head.done_res;

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 && !adv |=> vld_s1 && $stable(byte_s1) && $stable(last_s1))
		else $error("stalled input stage changed");

	a_pkt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> st_q.phase == PH_TYPE && st_q.count_written == 16'd0)
		else $error("state not cleared at end of packet");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> capacity_q == $past(cfg_data))
		else $error("capacity write lost");

endmodule

### hdl/tlvopf_step.sv
// Next-state and result logic for one option byte of the TLV pad filter.
// Purely combinational; depends on tlvopf_pkg.
`timescale 1ns / 1ps

module tlvopf_step (
	input  tlvopf_pkg::state_t st,
	input  logic [7:0]         in_byte,
	input  logic               last,
	input  logic [15:0]        capacity,
	output tlvopf_pkg::state_t st_next,
	output logic [1:0]         res_n,
	output tlvopf_pkg::res_t   res0,
	output tlvopf_pkg::res_t   res1
);
	import tlvopf_pkg::*;

	logic [15:0] cnt_p1;
	logic [15:0] cnt_p2;
	logic [7:0]  left_m1;
	logic        fits;

	assign cnt_p1  = st.count_written + 16'd1;
	assign cnt_p2  = st.count_written + 16'd2;
	assign left_m1 = st.bytes_left - 8'd1;
	assign fits    = ({2'b00, st.count_written} + {10'd0, in_byte} + HDR_OVERHEAD)
		< {2'b00, capacity};

	always_comb begin
		st_next = st;
		res_n   = 2'd0;
		res0    = '{out_byte: 8'd0, byte_valid: 1'b0, done_res: 1'b0,
			written_count: st.count_written};
		res1    = res0;
		case (st.phase)
			PH_PADLEN: begin
				st_next.bytes_left = in_byte;
				st_next.phase      = (in_byte == 8'd0) ? PH_TYPE : PH_PADSKIP;
			end
			PH_PADSKIP: begin
				st_next.bytes_left = left_m1;
				if (left_m1 == 8'd0) begin
					st_next.phase = PH_TYPE;
				end
			end
			PH_OPTLEN: begin
				if (fits) begin
					res0 = '{out_byte: st.held_type, byte_valid: 1'b1, done_res: 1'b0,
						written_count: cnt_p1};
					res1 = '{out_byte: in_byte, byte_valid: 1'b1, done_res: 1'b0,
						written_count: cnt_p2};
					res_n = 2'd2;
					st_next.count_written = cnt_p2;
					st_next.bytes_left    = in_byte;
					st_next.phase         = (in_byte == 8'd0) ? PH_TYPE : PH_OPTBODY;
				end else begin
					st_next.phase = PH_DRAIN;
				end
			end
			PH_OPTBODY: begin
				res0 = '{out_byte: in_byte, byte_valid: 1'b1, done_res: 1'b0,
					written_count: cnt_p1};
				res_n = 2'd1;
				st_next.count_written = cnt_p1;
				st_next.bytes_left    = left_m1;
				if (left_m1 == 8'd0) begin
					st_next.phase = PH_TYPE;
				end
			end
			PH_DRAIN: begin
				st_next.phase = PH_DRAIN;
			end
			default: begin
				if (st.count_written >= capacity) begin
					st_next.phase = PH_DRAIN;
				end else if (in_byte == TYPE_PAD1) begin
					st_next.phase = PH_TYPE;
				end else if (in_byte == TYPE_PADN) begin
					st_next.phase = PH_PADLEN;
				end else begin
					st_next.held_type = in_byte;
					st_next.phase     = PH_OPTLEN;
				end
			end
		endcase

		if (last) begin
			case (res_n)
				2'd0: begin
					res0.done_res = 1'b1;
					res_n         = 2'd1;
				end
				2'd1: begin
					res0.done_res = 1'b1;
				end
				default: begin
					res1.done_res = 1'b1;
				end
			endcase
			st_next = STATE_RESET;
		end
	end

endmodule

### hdl/tlvopf_outbuf.sv
// Two-entry result buffer between the filter logic and the output stream.
// Takes up to two results per cycle; depends on tlvopf_pkg.
`timescale 1ns / 1ps

module tlvopf_outbuf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [1:0]       push_n,
	input  tlvopf_pkg::res_t push0,
	input  tlvopf_pkg::res_t push1,
	input  logic             pop,
	output logic             head_valid,
	output tlvopf_pkg::res_t head,
	output logic [1:0]       space
);
	import tlvopf_pkg::*;

	res_t       slot_q [2];
	logic [1:0] cnt_q;
	logic [1:0] base;

	assign base       = cnt_q - {1'b0, pop};
	assign space      = 2'd2 - base;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = slot_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else begin
			cnt_q <= base + push_n;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n == 2'd2) begin
			slot_q[0] <= push0;
			slot_q[1] <= push1;
		end else if (push_n == 2'd1 && base == 2'd0) begin
			slot_q[0] <= push0;
		end else begin
			if (pop) begin
				slot_q[0] <= slot_q[1];
			end
			if (push_n == 2'd1) begin
				slot_q[1] <= push0;
			end
		end
	end

endmodule

### tb/sv/tlv_option_pad_filter_top_tb.sv
// Testbench for tlv_option_pad_filter_top: directed table, then random option areas with random
// stalls on both streams and capacity changes between phases, checked against a local model.
// Depends on tlvopf_pkg and tlv_option_pad_filter_top only.
`timescale 1ns / 1ps

module tlv_option_pad_filter_top_tb;
	import tlvopf_pkg::*;

	localparam int RANDOM_ITEMS = 1200;
	localparam int SETTLE_CYCLES = 8;
	localparam int END_CYCLES = 16;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PKTS_PER_PHASE = 14;
	localparam int MAX_PRINTS = 40;
	localparam logic ROW_CFG = 1'b1;
	localparam logic ROW_BYTE = 1'b0;
	localparam res_t NO_WORD = '0;

	typedef struct {
		logic        is_cfg;
		logic [15:0] value;
		logic        last;
		int          n_typed;
		res_t        e0;
		res_t        e1;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = '0;

	// Filter model state.
	phase_t      st_phase = PH_TYPE;
	logic [8:0]  st_left = '0;
	logic [7:0]  st_type = '0;
	logic [15:0] st_count = '0;
	logic [15:0] st_capacity = CAPACITY_RESET;
	res_t        step_out [2];
	int          step_n;

	res_t        pending_words [$];
	stim_row_t   directed_rows [$];
	logic [7:0]  pkt_bytes [$];
	int          error_count = 0;
	int          sent_words = 0;
	int          checked_words = 0;
	int          packet_count = 0;
	int          cfg_writes = 0;
	int          cycle_count = 0;
	bit          tx_burst = 1'b0;
	bit          rx_burst = 1'b0;

	tlv_option_pad_filter_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d words outstanding", cycle_count,
				pending_words.size());
			$display("tlv_option_pad_filter_top_tb: errors");
			$finish;
		end
	end

	function automatic res_t mk_word(input logic [7:0] b, input logic v, input logic d,
			input logic [15:0] c);
		mk_word = '{out_byte: b, byte_valid: v, done_res: d, written_count: c};
	endfunction

	function automatic int draw_gap(inout bit burst);
		if ($urandom_range(0, 47) == 0)
			burst = !burst;
		draw_gap = burst ? 0 : $urandom_range(0, 11);
	endfunction

	task report_mismatch(input string what, input res_t got, input res_t want);
		if (error_count < MAX_PRINTS)
			$display("%0t %s: got byte %02h valid %0d done %0d count %0d,",
				$realtime, what, got.out_byte, got.byte_valid, got.done_res,
				got.written_count, " want byte %02h valid %0d done %0d count %0d",
				want.out_byte, want.byte_valid, want.done_res, want.written_count);
		error_count++;
	endtask

	task emit_copy(input logic [7:0] b);
		st_count = st_count + 16'd1;
		step_out[step_n] = mk_word(b, 1'b1, 1'b0, st_count);
		step_n++;
	endtask

	// Advances the filter model by one input byte and leaves its output words in step_out.
	task strip_step(input logic [7:0] b, input logic last);
		step_n = 0;
		case (st_phase)
		PH_PADLEN: begin
			st_left = {1'b0, b};
			st_phase = (b == 8'd0) ? PH_TYPE : PH_PADSKIP;
		end
		PH_PADSKIP: begin
			st_left = st_left - 9'd1;
			if (st_left == 9'd0)
				st_phase = PH_TYPE;
		end
		PH_OPTLEN: begin
			if (int'(st_count) + int'(b) + int'(HDR_OVERHEAD) < int'(st_capacity)) begin
				emit_copy(st_type);
				emit_copy(b);
				st_left = {1'b0, b};
				st_phase = (b == 8'd0) ? PH_TYPE : PH_OPTBODY;
			end else begin
				st_phase = PH_DRAIN;
			end
		end
		PH_OPTBODY: begin
			emit_copy(b);
			st_left = st_left - 9'd1;
			if (st_left == 9'd0)
				st_phase = PH_TYPE;
		end
		PH_DRAIN: ;
		default: begin
			if (st_count >= st_capacity) begin
				st_phase = PH_DRAIN;
			end else if (b == TYPE_PAD1) begin
				st_phase = PH_TYPE;
			end else if (b == TYPE_PADN) begin
				st_phase = PH_PADLEN;
			end else begin
				st_type = b;
				st_phase = PH_OPTLEN;
			end
		end
		endcase
		if (last) begin
			if (step_n == 0) begin
				step_out[0] = mk_word(8'd0, 1'b0, 1'b0, st_count);
				step_n = 1;
			end
			step_out[step_n - 1].done_res = 1'b1;
			st_phase = PH_TYPE;
			st_left = '0;
			st_type = '0;
			st_count = '0;
		end
	endtask

	task send_byte(input logic [7:0] b, input logic last, input int n_typed, input res_t e0,
			input res_t e1);
		int gap;
		gap = draw_gap(tx_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		sent_words++;
		strip_step(b, last);
		if (n_typed > 0) begin
			pending_words.push_back(e0);
			if (n_typed > 1)
				pending_words.push_back(e1);
		end else begin
			for (int i = 0; i < step_n; i++)
				pending_words.push_back(step_out[i]);
		end
	endtask

	// The sender holds off until every expected word is back and the block has settled.
	task wait_drained();
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task write_capacity(input logic [15:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		st_capacity = value;
		cfg_writes++;
	endtask

	task add_row(input logic is_cfg, input logic [15:0] value, input logic last,
			input int n_typed, input res_t e0, input res_t e1);
		directed_rows.push_back('{is_cfg, value, last, n_typed, e0, e1});
	endtask

	// Builds one option area: mostly well-formed options, some cut short, some pure noise.
	task build_packet();
		int style;
		int n_opts;
		int kind;
		int len;
		pkt_bytes.delete();
		style = $urandom_range(0, 9);
		if (style == 0) begin
			repeat ($urandom_range(1, 12))
				pkt_bytes.push_back(8'($urandom_range(0, 255)));
		end else begin
			n_opts = $urandom_range(0, 5);
			for (int i = 0; i < n_opts; i++) begin
				kind = $urandom_range(0, 5);
				len = ($urandom_range(0, 39) == 0) ? $urandom_range(128, 255)
					: $urandom_range(0, 6);
				if (kind == 0) begin
					pkt_bytes.push_back(TYPE_PAD1);
				end else begin
					pkt_bytes.push_back((kind == 1) ? TYPE_PADN
						: 8'($urandom_range(2, 255)));
					pkt_bytes.push_back(8'(len));
					repeat (len) pkt_bytes.push_back(8'($urandom_range(0, 255)));
				end
			end
			if (style == 1 && pkt_bytes.size() > 1)
				while (pkt_bytes.size() > 1 && $urandom_range(0, 3) != 0)
					void'(pkt_bytes.pop_back());
		end
		if (pkt_bytes.size() == 0)
			pkt_bytes.push_back(TYPE_PAD1);
	endtask

	initial begin
		forever begin
			int gap;
			res_t got;
			res_t want;
			gap = draw_gap(rx_burst);
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && arst_n));
			got = mk_word(m_tdata[7:0], m_tuser, m_tlast, m_tdata[23:8]);
			if (pending_words.size() == 0) begin
				report_mismatch("unexpected word", got, NO_WORD);
			end else begin
				want = pending_words.pop_front();
				if (got.out_byte !== want.out_byte || got.byte_valid !== want.byte_valid
						|| got.done_res !== want.done_res
						|| got.written_count !== want.written_count)
					report_mismatch("word mismatch", got, want);
				checked_words++;
			end
		end
	end

	initial begin
		int phase_no;
		logic [15:0] cap;
		add_row(ROW_BYTE, 16'h00, 1'b1, 1, mk_word(8'h00, 1'b0, 1'b1, 16'd0), NO_WORD);
		add_row(ROW_BYTE, 16'hFF, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h00, 1'b1, 2, mk_word(8'hFF, 1'b1, 1'b0, 16'd1),
			mk_word(8'h00, 1'b1, 1'b1, 16'd2));
		add_row(ROW_BYTE, 16'h01, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h02, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'hAA, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h55, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h00, 1'b1, 1, mk_word(8'h00, 1'b0, 1'b1, 16'd0), NO_WORD);
		add_row(ROW_BYTE, 16'h01, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h00, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h02, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h03, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h11, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h80, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h7F, 1'b1, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'hC3, 1'b1, 1, mk_word(8'h00, 1'b0, 1'b1, 16'd0), NO_WORD);
		add_row(ROW_CFG, 16'd0, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h05, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h02, 1'b1, 1, mk_word(8'h00, 1'b0, 1'b1, 16'd0), NO_WORD);
		add_row(ROW_CFG, 16'd4, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h09, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h01, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'hEE, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h0A, 1'b0, 0, NO_WORD, NO_WORD);
		add_row(ROW_BYTE, 16'h00, 1'b1, 1, mk_word(8'h00, 1'b0, 1'b1, 16'd3), NO_WORD);
		add_row(ROW_CFG, 16'hFFFF, 1'b0, 0, NO_WORD, NO_WORD);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].is_cfg) begin
				wait_drained();
				write_capacity(directed_rows[i].value);
			end else begin
				send_byte(directed_rows[i].value[7:0], directed_rows[i].last,
					directed_rows[i].n_typed, directed_rows[i].e0, directed_rows[i].e1);
				if (directed_rows[i].last)
					packet_count++;
			end
		end

		phase_no = 0;
		while (sent_words < RANDOM_ITEMS + directed_rows.size()) begin
			if (packet_count % PKTS_PER_PHASE == 0) begin
				case (phase_no % 6)
				0: cap = 16'd0;
				1: cap = 16'hFFFF;
				2: cap = 16'($urandom_range(1, 3));
				3: cap = 16'($urandom_range(4, 40));
				4: cap = 16'($urandom_range(0, 65535));
				default: cap = 16'($urandom_range(41, 300));
				endcase
				wait_drained();
				write_capacity(cap);
				phase_no++;
			end
			build_packet();
			foreach (pkt_bytes[i])
				send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1, 0, NO_WORD, NO_WORD);
			packet_count++;
		end

		wait_drained();
		repeat (END_CYCLES) @(posedge clk);
		if (pending_words.size() != 0)
			report_mismatch("missing word", NO_WORD, pending_words[0]);
		$display("Sent %0d bytes in %0d option areas over %0d capacity settings,",
			sent_words, packet_count, cfg_writes);
		$display("and compared %0d output words with the model; %0d mismatches.",
			checked_words, error_count);
		if (error_count == 0)
			$display("tlv_option_pad_filter_top_tb: clean");
		else
			$display("tlv_option_pad_filter_top_tb: errors");
		$finish;
	end

endmodule
